### src/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// shared types and constants of the ansi sgr text console
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam logic [1:0] OP_PUT      = 2'd0;
  localparam logic [1:0] OP_SYNC     = 2'd1;
  localparam logic [1:0] OP_ENABLE   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] KIND_CELL         = 2'd0;
  localparam logic [1:0] KIND_CLEAR_ROW    = 2'd1;
  localparam logic [1:0] KIND_CLEAR_SCREEN = 2'd2;
  localparam logic [1:0] KIND_CURSOR       = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;

  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [3:0] BG_DEFAULT = 4'd0;

  typedef enum logic [1:0] {PH_TEXT, PH_ESCAPE, PH_CSI} esc_phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EN_CLR, S_EN_CUR, S_SYNC, S_PUT, S_BS, S_TAB,
    S_WRAP1, S_WRAP2, S_SGR
  } state_t;

  typedef enum logic [2:0] {
    PEN_NONE, PEN_INC, PEN_DEC, PEN_COL0, PEN_HOME, PEN_ROW_ADV
  } pen_op_t;

  typedef enum logic [2:0] {
    ESCOP_NONE, ESCOP_CLEAR, ESCOP_SEEN, ESCOP_START, ESCOP_DIGIT, ESCOP_SEMI,
    ESCOP_FINAL
  } esc_op_t;

  typedef enum logic [2:0] {
    EM_CELL_BYTE, EM_CELL_SPACE, EM_CLEAR_ROW, EM_CLEAR_SCREEN, EM_CURSOR_HOME,
    EM_CURSOR_PEN
  } emit_sel_t;

  typedef struct packed {
    logic      capture;
    logic      emit;
    emit_sel_t sel;
    logic      last;
    pen_op_t   pen_op;
    esc_op_t   esc_op;
    logic      sgr_step;
    logic      set_on;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       console_on;
    esc_phase_t phase;
    logic       is_esc;
    logic       is_cr;
    logic       is_lf;
    logic       is_bs;
    logic       is_tab;
    logic       is_print;
    logic       is_digit;
    logic       is_semi;
    logic       is_m;
    logic       is_lbr;
    logic       col_zero;
    logic       wrap_next;
    logic       tab_last;
    logic       sgr_done;
    logic       out_free;
  } status_t;

  // ansi colour order to vga palette order
  function automatic logic [2:0] ansi_to_pal(input logic [2:0] a);
    logic [2:0] r;
    unique case (a)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

### src/asc_ctrl.sv
// ----------------------------------------------------------------------------
// asc_ctrl
// sequencer of the console: decodes one command and steps its results
// ----------------------------------------------------------------------------
module asc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  asc_pkg::status_t st,
  output logic             in_stall,
  output asc_pkg::cmd_t    cmd
);

  asc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.sel      = asc_pkg::EM_CELL_BYTE;
    cmd.pen_op   = asc_pkg::PEN_NONE;
    cmd.esc_op   = asc_pkg::ESCOP_NONE;
    in_stall     = (state != asc_pkg::S_IDLE);
    unique case (state)
      asc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = asc_pkg::S_DECODE;
        end
      end
      asc_pkg::S_DECODE: begin
        state_next = asc_pkg::S_IDLE;
        if (st.op == asc_pkg::OP_ENABLE) begin
          state_next = asc_pkg::S_EN_CLR;
        end else if (st.op == asc_pkg::OP_SYNC && st.console_on) begin
          state_next = asc_pkg::S_SYNC;
        end else if (st.op == asc_pkg::OP_PUT && st.console_on) begin
          priority case (st.phase)
            asc_pkg::PH_ESCAPE: begin
              cmd.esc_op = st.is_lbr ? asc_pkg::ESCOP_START : asc_pkg::ESCOP_CLEAR;
            end
            asc_pkg::PH_CSI: begin
              priority if (st.is_digit) begin
                cmd.esc_op = asc_pkg::ESCOP_DIGIT;
              end else if (st.is_semi) begin
                cmd.esc_op = asc_pkg::ESCOP_SEMI;
              end else if (st.is_m) begin
                cmd.esc_op = asc_pkg::ESCOP_FINAL;
                state_next = asc_pkg::S_SGR;
              end else begin
                cmd.esc_op = asc_pkg::ESCOP_CLEAR;
              end
            end
            default: begin
              priority if (st.is_esc) begin
                cmd.esc_op = asc_pkg::ESCOP_SEEN;
              end else if (st.is_cr) begin
                cmd.pen_op = asc_pkg::PEN_COL0;
              end else if (st.is_lf) begin
                state_next = asc_pkg::S_WRAP1;
              end else if (st.is_bs) begin
                if (!st.col_zero) begin
                  cmd.pen_op = asc_pkg::PEN_DEC;
                  state_next = asc_pkg::S_BS;
                end
              end else if (st.is_tab) begin
                state_next = asc_pkg::S_TAB;
              end else if (st.is_print) begin
                state_next = asc_pkg::S_PUT;
              end
            end
          endcase
        end
      end
      asc_pkg::S_EN_CLR: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CLEAR_SCREEN;
          state_next = asc_pkg::S_EN_CUR;
        end
      end
      asc_pkg::S_EN_CUR: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CURSOR_HOME;
          cmd.last   = 1'b1;
          cmd.pen_op = asc_pkg::PEN_HOME;
          cmd.set_on = 1'b1;
          state_next = asc_pkg::S_IDLE;
        end
      end
      asc_pkg::S_SYNC: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CURSOR_PEN;
          cmd.last   = 1'b1;
          state_next = asc_pkg::S_IDLE;
        end
      end
      asc_pkg::S_PUT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CELL_BYTE;
          cmd.last   = !st.wrap_next;
          cmd.pen_op = asc_pkg::PEN_INC;
          state_next = st.wrap_next ? asc_pkg::S_WRAP1 : asc_pkg::S_IDLE;
        end
      end
      asc_pkg::S_BS: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CELL_SPACE;
          cmd.last   = 1'b1;
          state_next = asc_pkg::S_IDLE;
        end
      end
      asc_pkg::S_TAB: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CELL_SPACE;
          cmd.last   = st.tab_last;
          cmd.pen_op = asc_pkg::PEN_INC;
          priority if (st.wrap_next) begin
            state_next = asc_pkg::S_WRAP1;
          end else if (st.tab_last) begin
            state_next = asc_pkg::S_IDLE;
          end
        end
      end
      asc_pkg::S_WRAP1: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CLEAR_ROW;
          cmd.pen_op = asc_pkg::PEN_ROW_ADV;
          state_next = asc_pkg::S_WRAP2;
        end
      end
      asc_pkg::S_WRAP2: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = asc_pkg::EM_CLEAR_ROW;
          cmd.last   = 1'b1;
          state_next = asc_pkg::S_IDLE;
        end
      end
      asc_pkg::S_SGR: begin
        cmd.sgr_step = 1'b1;
        if (st.sgr_done) begin
          state_next = asc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = asc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/asc_dp.sv
// ----------------------------------------------------------------------------
// asc_dp
// console datapath: pen, colours, escape parser, parameter store, result register
// ----------------------------------------------------------------------------
module asc_dp #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int MAX_PARAMS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  asc_pkg::cmd_t    cmd,
  output asc_pkg::status_t st,
  input  logic [1:0]       op,
  input  logic [7:0]       byte_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [10:0]      position,
  output logic [7:0]       glyph,
  output logic [7:0]       attribute,
  output logic             last
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int AW  = RW + 9;
  localparam int PCW = $clog2(MAX_PARAMS + 1);
  localparam int PIW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  logic [1:0]           op_q;
  logic [7:0]           byte_q;
  logic                 console_on;
  logic [CW-1:0]        pen_column;
  logic [RW-1:0]        pen_row;
  logic [3:0]           fore_colour;
  logic [3:0]           back_colour;
  logic                 bold_flag;
  asc_pkg::esc_phase_t  escape_phase;
  logic [7:0]           param_store [MAX_PARAMS];
  logic [PCW-1:0]       param_count;
  logic [7:0]           param_accum;
  logic [PIW-1:0]       sgr_index;

  logic [CW:0]          col_inc;
  logic [RW-1:0]        row_next;
  logic [AW-1:0]        addr_full;
  logic [11:0]          acc_mul;
  logic [7:0]           acc_sat;
  logic                 push_ok;
  logic [7:0]           p;
  logic [7:0]           p_off30, p_off40, p_off90, p_off100;
  logic                 out_free;

  assign col_inc   = {1'b0, pen_column} + (CW+1)'(1);
  assign row_next  = (pen_row == RW'(ROWS - 1)) ? '0 : pen_row + RW'(1);
  assign addr_full = AW'(pen_row) * AW'(COLUMNS) + AW'(pen_column);
  assign acc_mul   = {4'd0, param_accum} * 12'd10 + {4'd0, byte_q - asc_pkg::CH_ZERO};
  assign acc_sat   = (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
  assign push_ok   = (param_count < PCW'(MAX_PARAMS));
  assign out_free  = !out_valid || !out_stall;
  assign p         = param_store[sgr_index];
  assign p_off30   = p - 8'd30;
  assign p_off40   = p - 8'd40;
  assign p_off90   = p - 8'd90;
  assign p_off100  = p - 8'd100;

  always_comb begin
    st            = '0;
    st.op         = op_q;
    st.console_on = console_on;
    st.phase      = escape_phase;
    st.is_esc     = (byte_q == asc_pkg::CH_ESC);
    st.is_cr      = (byte_q == asc_pkg::CH_CR);
    st.is_lf      = (byte_q == asc_pkg::CH_LF);
    st.is_bs      = (byte_q == asc_pkg::CH_BS);
    st.is_tab     = (byte_q == asc_pkg::CH_TAB);
    st.is_print   = (byte_q >= asc_pkg::CH_SPACE) && (byte_q <= asc_pkg::CH_TILDE);
    st.is_digit   = (byte_q >= asc_pkg::CH_ZERO) && (byte_q <= asc_pkg::CH_NINE);
    st.is_semi    = (byte_q == asc_pkg::CH_SEMI);
    st.is_m       = (byte_q == asc_pkg::CH_M);
    st.is_lbr     = (byte_q == asc_pkg::CH_LBR);
    st.col_zero   = (pen_column == '0);
    st.wrap_next  = (col_inc >= (CW+1)'(COLUMNS));
    st.tab_last   = (col_inc[1:0] == 2'd0) && !st.wrap_next;
    st.sgr_done   = ((PCW'(sgr_index) + PCW'(1)) >= param_count);
    st.out_free   = out_free;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      byte_q <= byte_in;
    end
  end

  // pen and console enable
  always_ff @(posedge clk) begin
    if (rst) begin
      console_on <= 1'b0;
      pen_column <= '0;
      pen_row    <= '0;
    end else begin
      if (cmd.set_on) begin
        console_on <= 1'b1;
      end
      unique case (cmd.pen_op)
        asc_pkg::PEN_INC:     pen_column <= col_inc[CW-1:0];
        asc_pkg::PEN_DEC:     pen_column <= pen_column - CW'(1);
        asc_pkg::PEN_COL0:    pen_column <= '0;
        asc_pkg::PEN_HOME: begin
          pen_column <= '0;
          pen_row    <= '0;
        end
        asc_pkg::PEN_ROW_ADV: begin
          pen_column <= '0;
          pen_row    <= row_next;
        end
        default: ;
      endcase
    end
  end

  // escape parser
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= asc_pkg::PH_TEXT;
      param_count  <= '0;
      param_accum  <= '0;
    end else begin
      unique case (cmd.esc_op)
        asc_pkg::ESCOP_CLEAR: escape_phase <= asc_pkg::PH_TEXT;
        asc_pkg::ESCOP_SEEN:  escape_phase <= asc_pkg::PH_ESCAPE;
        asc_pkg::ESCOP_START: begin
          escape_phase <= asc_pkg::PH_CSI;
          param_count  <= '0;
          param_accum  <= '0;
        end
        asc_pkg::ESCOP_DIGIT: param_accum <= acc_sat;
        asc_pkg::ESCOP_SEMI: begin
          if (push_ok) begin
            param_count <= param_count + PCW'(1);
          end
          param_accum <= '0;
        end
        asc_pkg::ESCOP_FINAL: begin
          if (push_ok) begin
            param_count <= param_count + PCW'(1);
          end
          escape_phase <= asc_pkg::PH_TEXT;
        end
        default: ;
      endcase
    end
  end

  // parameter store
  always_ff @(posedge clk) begin
    if ((cmd.esc_op == asc_pkg::ESCOP_SEMI || cmd.esc_op == asc_pkg::ESCOP_FINAL)
        && push_ok) begin
      param_store[param_count[PIW-1:0]] <= param_accum;
    end
  end

  // sgr walk over the stored parameters
  always_ff @(posedge clk) begin
    if (rst) begin
      sgr_index   <= '0;
      fore_colour <= asc_pkg::FG_DEFAULT;
      back_colour <= asc_pkg::BG_DEFAULT;
      bold_flag   <= 1'b0;
    end else if (cmd.esc_op == asc_pkg::ESCOP_FINAL) begin
      sgr_index <= '0;
    end else if (cmd.sgr_step) begin
      sgr_index <= sgr_index + PIW'(1);
      priority if (p == 8'd0) begin
        fore_colour <= asc_pkg::FG_DEFAULT;
        back_colour <= asc_pkg::BG_DEFAULT;
        bold_flag   <= 1'b0;
      end else if (p == 8'd1) begin
        bold_flag <= 1'b1;
      end else if (p == 8'd22) begin
        bold_flag <= 1'b0;
      end else if (p >= 8'd30 && p <= 8'd37) begin
        fore_colour <= {bold_flag, asc_pkg::ansi_to_pal(p_off30[2:0])};
      end else if (p == 8'd39) begin
        fore_colour <= asc_pkg::FG_DEFAULT;
      end else if (p >= 8'd40 && p <= 8'd47) begin
        back_colour <= {1'b0, asc_pkg::ansi_to_pal(p_off40[2:0])};
      end else if (p == 8'd49) begin
        back_colour <= asc_pkg::BG_DEFAULT;
      end else if (p >= 8'd90 && p <= 8'd97) begin
        fore_colour <= {1'b1, asc_pkg::ansi_to_pal(p_off90[2:0])};
      end else if (p >= 8'd100 && p <= 8'd107) begin
        back_colour <= {1'b1, asc_pkg::ansi_to_pal(p_off100[2:0])};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      unique case (cmd.sel)
        asc_pkg::EM_CELL_BYTE: begin
          kind      <= asc_pkg::KIND_CELL;
          position  <= addr_full[10:0];
          glyph     <= byte_q;
          attribute <= {back_colour, fore_colour};
        end
        asc_pkg::EM_CELL_SPACE: begin
          kind      <= asc_pkg::KIND_CELL;
          position  <= addr_full[10:0];
          glyph     <= asc_pkg::CH_SPACE;
          attribute <= {back_colour, fore_colour};
        end
        asc_pkg::EM_CLEAR_ROW: begin
          kind      <= asc_pkg::KIND_CLEAR_ROW;
          position  <= 11'(row_next);
          glyph     <= asc_pkg::CH_SPACE;
          attribute <= asc_pkg::ATTR_DEFAULT;
        end
        asc_pkg::EM_CLEAR_SCREEN: begin
          kind      <= asc_pkg::KIND_CLEAR_SCREEN;
          position  <= '0;
          glyph     <= asc_pkg::CH_SPACE;
          attribute <= asc_pkg::ATTR_DEFAULT;
        end
        asc_pkg::EM_CURSOR_HOME: begin
          kind      <= asc_pkg::KIND_CURSOR;
          position  <= '0;
          glyph     <= '0;
          attribute <= '0;
        end
        default: begin
          kind      <= asc_pkg::KIND_CURSOR;
          position  <= addr_full[10:0];
          glyph     <= '0;
          attribute <= '0;
        end
      endcase
    end
  end

endmodule

### src/ansi_sgr_text_console.sv
// ----------------------------------------------------------------------------
// ansi_sgr_text_console
// text-mode terminal engine with an esc [ ... m colour parser
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one item of op and byte_in
//   (put byte, sync cursor, enable console); an item is taken when in_valid
//   is high and in_stall low
// output channel: out_valid / out_stall carry screen commands (kind,
//   position, glyph, attribute, last); last marks the final result of an item
// one item at a time: capture, decode, then one result per cycle from the
//   result register while the receiver does not stall; an item may give no
//   result, and at most six (a tab ending in a line wrap)
// an sgr final byte walks the stored parameters one per cycle, at most
//   MAX_PARAMS of them
// in_stall stays high until the sequencer is back in idle
// when the receiver stalls, the held result stays put and the sequencer
//   waits in its emitting state, so nothing is lost or repeated
// reset (rst, synchronous) turns the console off, homes the pen, restores
//   light grey on black and clears the parser; stored parameters are not
//   cleared, as only written entries are ever read
// ----------------------------------------------------------------------------
module ansi_sgr_text_console #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int MAX_PARAMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [10:0] position,
  output logic [7:0]  glyph,
  output logic [7:0]  attribute,
  output logic        last
);

  // command and status between sequencer and datapath
  asc_pkg::cmd_t    cmd;
  asc_pkg::status_t st;

  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  asc_dp #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .op        (op),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .position  (position),
    .glyph     (glyph),
    .attribute (attribute),
    .last      (last)
  );

endmodule
